@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising edge, off in reset.
`define CHK_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen on a sampled edge.
`define CHK_NEVER(lbl, ck, rstn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ design/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int ID_W     = 4;
    localparam int EV_W     = 4;
    localparam int MODE_W   = 3;
    localparam int ID_SPACE = 16;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_TICK   = 3'd0;
    localparam mode_t MODE_ADD    = 3'd1;
    localparam mode_t MODE_WAIT   = 3'd2;
    localparam mode_t MODE_SLEEP  = 3'd3;
    localparam mode_t MODE_RESUME = 3'd4;
    localparam mode_t MODE_EXIT   = 3'd5;

    localparam logic [EV_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EV_W-1:0] SLEEP_EVENT = 4'd1;

    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_WAITING = 2'd1,
        TS_RUNNING = 2'd2,
        TS_ZOMBIE  = 2'd3
    } task_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RES_RD,
        ST_RES_CHK,
        ST_RS_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RS_FOUND,
        ST_RS_FINISH,
        ST_REPORT
    } fsm_state_t;

endpackage

@@ design/round_robin_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin ready-queue scheduler: a FIFO of task ids plus per-task status,
// wait event and wake time, driven one command at a time by a sequencer.
// ----------------------------------------------------------------------------
//  Channel   Signals                                         Handshake
//  command   mode task_id event_type now_ms sleep_ms         start & !busy
//  result    running_task switched woke_any queue_full       done, one cycle
//  config    idle_task                                       idle_task_we
//
//  A command runs from a short add up to a reschedule that walks the
//  whole queue and shifts out an entry.
//  The queue is a memory with one write port and one registered read
//  port: each entry visited in a scan or a shift takes an address
//  state, then a data state.
//  Reset is asynchronous and takes effect at once; there is no clearing pass.
//  The result beat cannot be stalled; a new command may start in the cycle
//  that done is high.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [3:0]  task_id,
    input  logic [3:0]  event_type,
    input  logic [31:0] now_ms,
    input  logic [31:0] sleep_ms,
    input  logic        idle_task_we,
    input  logic [3:0]  idle_task,
    output logic        done,
    output logic [3:0]  running_task,
    output logic        switched,
    output logic        woke_any,
    output logic        queue_full
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = $clog2(MAX_TASKS);
    localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam int IDW = rrts_pkg::ID_W;

    // ---------------------------------------------------------------- state
    rrts_pkg::fsm_state_t state_reg, state_next;

    rrts_pkg::mode_t        mode_reg, mode_next;
    logic [IDW-1:0]         tid_reg, tid_next;
    logic [rrts_pkg::EV_W-1:0] ev_reg, ev_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [31:0]            dur_reg, dur_next;

    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           run_valid_reg, run_valid_next;
    logic [IDW-1:0] run_id_reg, run_id_next;
    logic [IDW-1:0] idle_reg;
    logic           had_reg, had_next;
    logic [IDW-1:0] prev_reg, prev_next;
    logic           cur_runs_reg, cur_runs_next;
    logic           found_reg, found_next;
    logic [IDW-1:0] found_id_reg, found_id_next;
    logic           drop_reg, drop_next;
    logic           woke_reg, woke_next;
    logic           sw_reg, sw_next;

    logic           done_reg, done_next;
    logic [IDW-1:0] out_task_reg;
    logic           out_sw_reg, out_woke_reg, out_full_reg;

    // Per-task tables, indexed by task id
    rrts_pkg::task_status_t    status_reg [rrts_pkg::ID_SPACE];
    logic [rrts_pkg::EV_W-1:0] kind_reg   [rrts_pkg::ID_SPACE];
    logic [TIME_BITS-1:0]      wake_reg   [rrts_pkg::ID_SPACE];

    // Queue memory, one write port and one read port
    logic [IDW-1:0] q_mem [MAX_TASKS];
    logic [IDW-1:0] q_rd_reg;
    logic           q_we;
    logic [IW-1:0]  q_wa, q_ra;
    logic [IDW-1:0] q_wd;

    // Task table ports
    logic                      st_we, kw_we;
    logic [IDW-1:0]            tw_addr;
    rrts_pkg::task_status_t    st_wd;
    logic [rrts_pkg::EV_W-1:0] kind_wd;
    logic [TIME_BITS-1:0]      wake_wd;

    logic [IDW-1:0]            t_ra;
    rrts_pkg::task_status_t    rd_status;
    logic [rrts_pkg::EV_W-1:0] rd_kind;
    logic [TIME_BITS-1:0]      rd_wake;

    logic [SW-1:0]        sum_w, mask_ext;
    logic [TIME_BITS-1:0] wake_sum;
    logic [CW-1:0]        idx_inc;
    logic                 q_has_room;
    logic                 hit_ready, hit_wake;
    logic [IDW-1:0]       pick;

    // ------------------------------------------------------ shared datapath
    assign t_ra = (state_reg == rrts_pkg::ST_SCAN_CHK || state_reg == rrts_pkg::ST_RES_CHK)
                  ? q_rd_reg : run_id_reg;
    assign rd_status = status_reg[t_ra];
    assign rd_kind   = kind_reg[t_ra];
    assign rd_wake   = wake_reg[t_ra];

    assign sum_w    = SW'(now_reg) + SW'(dur_reg);
    assign mask_ext = (SW'(1) << TIME_BITS) - SW'(1);
    assign wake_sum = (sum_w > mask_ext) ? {TIME_BITS{1'b1}} : sum_w[TIME_BITS-1:0];

    assign idx_inc    = idx_reg + CW'(1);
    assign q_has_room = (count_reg < CW'(MAX_TASKS));

    assign hit_ready = (rd_status == rrts_pkg::TS_READY);
    assign hit_wake  = (rd_status == rrts_pkg::TS_WAITING) &&
                       (rd_kind == rrts_pkg::SLEEP_EVENT) &&
                       (rd_wake != '0) && (now_reg >= rd_wake);

    assign pick = found_reg ? found_id_reg : (cur_runs_reg ? run_id_reg : idle_reg);

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        tid_next       = tid_reg;
        ev_next        = ev_reg;
        now_next       = now_reg;
        dur_next       = dur_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        had_next       = had_reg;
        prev_next      = prev_reg;
        cur_runs_next  = cur_runs_reg;
        found_next     = found_reg;
        found_id_next  = found_id_reg;
        drop_next      = drop_reg;
        woke_next      = woke_reg;
        sw_next        = sw_reg;
        done_next      = 1'b0;

        q_we    = 1'b0;
        q_wa    = count_reg[IW-1:0];
        q_wd    = run_id_reg;
        q_ra    = idx_reg[IW-1:0];
        st_we   = 1'b0;
        kw_we   = 1'b0;
        tw_addr = run_id_reg;
        st_wd   = rrts_pkg::TS_READY;
        kind_wd = rrts_pkg::EV_NONE;
        wake_wd = '0;

        unique case (state_reg)
            rrts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    mode_next  = rrts_pkg::mode_t'(mode);
                    tid_next   = task_id;
                    ev_next    = event_type;
                    now_next   = TIME_BITS'(now_ms);
                    dur_next   = sleep_ms;
                    drop_next  = 1'b0;
                    woke_next  = 1'b0;
                    sw_next    = 1'b0;
                    state_next = rrts_pkg::ST_EXEC;
                end
            end

            rrts_pkg::ST_EXEC:
            begin
                unique case (mode_reg)
                    rrts_pkg::MODE_TICK:
                        state_next = rrts_pkg::ST_RS_CHECK;
                    rrts_pkg::MODE_ADD:
                    begin
                        if (q_has_room)
                        begin
                            q_we       = 1'b1;
                            q_wd       = tid_reg;
                            count_next = count_reg + CW'(1);
                            st_we      = 1'b1;
                            kw_we      = 1'b1;
                            tw_addr    = tid_reg;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                        state_next = rrts_pkg::ST_REPORT;
                    end
                    rrts_pkg::MODE_WAIT:
                    begin
                        if (run_valid_reg)
                        begin
                            st_we   = 1'b1;
                            kw_we   = 1'b1;
                            st_wd   = rrts_pkg::TS_WAITING;
                            kind_wd = ev_reg;
                        end
                        state_next = rrts_pkg::ST_RS_CHECK;
                    end
                    rrts_pkg::MODE_SLEEP:
                    begin
                        if (run_valid_reg)
                        begin
                            st_we      = 1'b1;
                            kw_we      = 1'b1;
                            st_wd      = rrts_pkg::TS_WAITING;
                            kind_wd    = rrts_pkg::SLEEP_EVENT;
                            wake_wd    = wake_sum;
                            state_next = rrts_pkg::ST_RS_CHECK;
                        end
                        else
                        begin
                            state_next = rrts_pkg::ST_REPORT;
                        end
                    end
                    rrts_pkg::MODE_RESUME:
                    begin
                        idx_next   = '0;
                        state_next = rrts_pkg::ST_RES_RD;
                    end
                    rrts_pkg::MODE_EXIT:
                    begin
                        if (run_valid_reg)
                        begin
                            st_we          = 1'b1;
                            st_wd          = rrts_pkg::TS_ZOMBIE;
                            run_valid_next = 1'b0;
                        end
                        state_next = rrts_pkg::ST_RS_CHECK;
                    end
                    default:
                        state_next = rrts_pkg::ST_REPORT;
                endcase
            end

            rrts_pkg::ST_RES_RD:
            begin
                if (idx_reg < count_reg)
                    state_next = rrts_pkg::ST_RES_CHK;
                else
                    state_next = rrts_pkg::ST_REPORT;
            end

            rrts_pkg::ST_RES_CHK:
            begin
                if (rd_status == rrts_pkg::TS_WAITING && rd_kind == ev_reg)
                begin
                    st_we     = 1'b1;
                    tw_addr   = q_rd_reg;
                    woke_next = 1'b1;
                end
                idx_next   = idx_inc;
                state_next = rrts_pkg::ST_RES_RD;
            end

            rrts_pkg::ST_RS_CHECK:
            begin
                had_next      = run_valid_reg;
                prev_next     = run_id_reg;
                cur_runs_next = 1'b0;
                found_next    = 1'b0;
                if (run_valid_reg && run_id_reg != idle_reg)
                begin
                    // requeue a current task that no longer runs
                    if (rd_status != rrts_pkg::TS_RUNNING)
                    begin
                        if (q_has_room)
                        begin
                            q_we       = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_runs_next = 1'b1;
                    end
                end
                idx_next   = '0;
                state_next = rrts_pkg::ST_SCAN_RD;
            end

            rrts_pkg::ST_SCAN_RD:
            begin
                if (idx_reg < count_reg)
                    state_next = rrts_pkg::ST_SCAN_CHK;
                else
                    state_next = rrts_pkg::ST_RS_FINISH;
            end

            rrts_pkg::ST_SCAN_CHK:
            begin
                if (hit_ready || hit_wake)
                begin
                    if (!hit_ready)
                    begin
                        // disarm the expired sleep
                        kw_we   = 1'b1;
                        tw_addr = q_rd_reg;
                    end
                    found_next    = 1'b1;
                    found_id_next = q_rd_reg;
                    state_next    = rrts_pkg::ST_SHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = rrts_pkg::ST_SCAN_RD;
                end
            end

            rrts_pkg::ST_SHIFT_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    q_ra       = idx_inc[IW-1:0];
                    state_next = rrts_pkg::ST_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = rrts_pkg::ST_RS_FOUND;
                end
            end

            rrts_pkg::ST_SHIFT_WR:
            begin
                q_we       = 1'b1;
                q_wa       = idx_reg[IW-1:0];
                q_wd       = q_rd_reg;
                idx_next   = idx_inc;
                state_next = rrts_pkg::ST_SHIFT_RD;
            end

            rrts_pkg::ST_RS_FOUND:
            begin
                if (cur_runs_reg)
                begin
                    st_we = 1'b1;
                    if (q_has_room)
                    begin
                        q_we       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                state_next = rrts_pkg::ST_RS_FINISH;
            end

            rrts_pkg::ST_RS_FINISH:
            begin
                st_we          = 1'b1;
                st_wd          = rrts_pkg::TS_RUNNING;
                tw_addr        = pick;
                run_valid_next = 1'b1;
                run_id_next    = pick;
                sw_next        = !had_reg || (prev_reg != pick);
                state_next     = rrts_pkg::ST_REPORT;
            end

            rrts_pkg::ST_REPORT:
            begin
                done_next  = 1'b1;
                state_next = rrts_pkg::ST_IDLE;
            end

            default:
                state_next = rrts_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrts_pkg::ST_IDLE;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            idle_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            done_reg      <= done_next;
            if (idle_task_we)
                idle_reg <= idle_task;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        tid_reg      <= tid_next;
        ev_reg       <= ev_next;
        now_reg      <= now_next;
        dur_reg      <= dur_next;
        idx_reg      <= idx_next;
        had_reg      <= had_next;
        prev_reg     <= prev_next;
        cur_runs_reg <= cur_runs_next;
        found_reg    <= found_next;
        found_id_reg <= found_id_next;
        drop_reg     <= drop_next;
        woke_reg     <= woke_next;
        sw_reg       <= sw_next;
        if (done_next)
        begin
            out_task_reg <= run_valid_reg ? run_id_reg : '0;
            out_sw_reg   <= sw_reg;
            out_woke_reg <= woke_reg;
            out_full_reg <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrts_pkg::ID_SPACE; i++)
            begin
                status_reg[i] <= rrts_pkg::TS_READY;
                kind_reg[i]   <= rrts_pkg::EV_NONE;
                wake_reg[i]   <= '0;
            end
        end
        else
        begin
            if (st_we)
                status_reg[tw_addr] <= st_wd;
            if (kw_we)
            begin
                kind_reg[tw_addr] <= kind_wd;
                wake_reg[tw_addr] <= wake_wd;
            end
        end
    end

    // Queue memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_wa] <= q_wd;
    end

    always_ff @(posedge clk)
    begin
        q_rd_reg <= q_mem[q_ra];
    end

    // -------------------------------------------------------------- outputs
    assign busy         = (state_reg != rrts_pkg::ST_IDLE);
    assign done         = done_reg;
    assign running_task = out_task_reg;
    assign switched     = out_sw_reg;
    assign woke_any     = out_woke_reg;
    assign queue_full   = out_full_reg;

endmodule

@@ design/rrts_checker.sv @@
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler's command and result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       switched,
    input logic       woke_any
);

    // A result beat leaves the block free for the next command
    `CHK_NEVER(a_done_not_busy, clk, rst_n, done && busy, "result beat while busy")

    // An accepted command holds the block busy, with no result beat, in the next cycle
    `CHK_ASSERT(a_cmd_busy, clk, rst_n, (start && !busy) |=> (busy && !done), "command not held")

    // Every result beat ends a command that was in flight
    `CHK_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(busy), "result beat without a command")

    // Resume never reschedules, so a wake report carries no switch
    `CHK_NEVER(a_woke_no_switch, clk, rst_n, done && woke_any && switched, "woke and switched together")

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .switched     (switched),
    .woke_any     (woke_any)
);
